### sv/fixed_sine_cosine_poly_assert.svh
// Assertion macros for the sine and cosine pipeline.
`ifndef FIXED_SINE_COSINE_POLY_ASSERT_SVH
`define FIXED_SINE_COSINE_POLY_ASSERT_SVH

`ifndef SYNTHESIS
`define SFCP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SFCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SFCP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SFCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/sfcp_pkg.sv
package sfcp_pkg;

	localparam logic [31:0] POLY_A1 = 32'd3370945099;
	localparam logic [31:0] POLY_B1 = 32'd2746362156;
	localparam logic [31:0] POLY_C1 = 32'd2339369;

	localparam logic [10:0] QUARTER   = 11'd1024;
	localparam logic [32:0] ROUND_ADD = 33'd16384;
	localparam logic [17:0] ONE_FIXED = 18'd65536;

	localparam int FOLD_STAGE = 1;
	localparam int POLY_FIRST = 2;
	localparam int POLY_LAST  = 9;
	localparam int OUT_STAGE  = 10;

	typedef logic [10:0] u_t;
	typedef logic [17:0] mag_t;
	typedef logic [31:0] word_t;

	typedef struct packed {
		logic sneg;
		logic cneg;
		logic spec;
	} flag_t;

endpackage

### sv/sfcp_poly.sv
module sfcp_poly (
	input  logic                                              clk,
	input  sfcp_pkg::u_t                                      u,
	input  logic [sfcp_pkg::POLY_LAST:sfcp_pkg::POLY_FIRST]   adv,
	output sfcp_pkg::mag_t                                    mag
);

	sfcp_pkg::u_t    u_s2, u_s3, u_s4, u_s5, u_s6, u_s7;
	sfcp_pkg::word_t m1_s2, m2_s3, y2_s4, m3_s5, m4_s6, y5_s7, m5_s8;
	sfcp_pkg::mag_t  mag_s9;
	logic [32:0]     rnd;

	assign rnd = {1'b0, m5_s8} + sfcp_pkg::ROUND_ADD;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			u_s2  <= u;
			m1_s2 <= sfcp_pkg::POLY_C1 * {21'd0, u};
		end
		if (adv[3]) begin
			u_s3  <= u_s2;
			m2_s3 <= {21'd0, u_s2} * {10'd0, m1_s2[31:10]};
		end
		if (adv[4]) begin
			u_s4  <= u_s3;
			y2_s4 <= sfcp_pkg::POLY_B1 - {3'd0, m2_s3[31:3]};
		end
		if (adv[5]) begin
			u_s5  <= u_s4;
			m3_s5 <= {21'd0, u_s4} * {10'd0, y2_s4[31:10]};
		end
		if (adv[6]) begin
			u_s6  <= u_s5;
			m4_s6 <= {21'd0, u_s5} * {10'd0, m3_s5[31:10]};
		end
		if (adv[7]) begin
			u_s7  <= u_s6;
			y5_s7 <= sfcp_pkg::POLY_A1 - {1'b0, m4_s6[31:1]};
		end
		if (adv[8]) begin
			m5_s8 <= {21'd0, u_s7} * {10'd0, y5_s7[31:10]};
		end
		if (adv[9]) begin
			mag_s9 <= rnd[32:15];
		end
	end

	assign mag = mag_s9;

endmodule

### sv/fixed_sine_cosine_poly.sv
// Sine and cosine of a 12-bit binary angle (4096 units per turn, upper input bits
// ignored), both in signed Q2.16 format. The block is a ten-stage pipeline: one
// fold stage, seven stages of the polynomial (five multiplies and two subtracts,
// each in its own stage, one lane for sine and one for cosine), a rounding stage
// and the output register. It takes one angle per cycle until a stalled output
// backs the pipeline up to its input, and each result passes through every stage
// before it transfers out. A stalled output holds only the stages behind it that
// are full, so empty stages keep accepting new angles.
`include "fixed_sine_cosine_poly_assert.svh"

module fixed_sine_cosine_poly (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                angle_valid,
	output logic                angle_ready,
	input  logic signed [15:0]  angle,
	output logic                result_valid,
	input  logic                result_ready,
	output logic signed [17:0]  sine,
	output logic signed [17:0]  cosine
);

	localparam int NST = sfcp_pkg::OUT_STAGE;

	logic [NST:1]           valid_q;
	logic [NST+1:1]         en;

	logic [1:0]             quad;
	logic [9:0]             off;
	sfcp_pkg::u_t           off_ext;
	sfcp_pkg::u_t           off_inv;
	sfcp_pkg::u_t           xs_s1, xc_s1;
	sfcp_pkg::flag_t        flag_s [sfcp_pkg::FOLD_STAGE:sfcp_pkg::POLY_LAST];
	sfcp_pkg::mag_t         smag, cmag;
	logic [17:0]            sine_nx, cosine_nx;
	logic signed [17:0]     sine_s10, cosine_s10;
	sfcp_pkg::flag_t        flag_last;

	always_comb begin
		en[NST+1] = result_ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign angle_ready  = en[1];
	assign result_valid = valid_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= angle_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign quad    = angle[11:10];
	assign off     = angle[9:0];
	assign off_ext = {1'b0, off};
	assign off_inv = sfcp_pkg::QUARTER - off_ext;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xs_s1            <= quad[0] ? off_inv : off_ext;
			xc_s1            <= quad[0] ? off_ext : off_inv;
			flag_s[1].sneg   <= quad[1];
			flag_s[1].cneg   <= quad[0] ^ quad[1];
			flag_s[1].spec   <= quad[0] && (off == 10'd0);
		end
		for (int k = sfcp_pkg::POLY_FIRST; k <= sfcp_pkg::POLY_LAST; k++) begin
			if (en[k]) begin
				flag_s[k] <= flag_s[k-1];
			end
		end
	end

	sfcp_poly u_sine (
		.clk (clk),
		.u   (xs_s1),
		.adv (en[sfcp_pkg::POLY_LAST:sfcp_pkg::POLY_FIRST]),
		.mag (smag)
	);

	sfcp_poly u_cosine (
		.clk (clk),
		.u   (xc_s1),
		.adv (en[sfcp_pkg::POLY_LAST:sfcp_pkg::POLY_FIRST]),
		.mag (cmag)
	);

	assign flag_last = flag_s[sfcp_pkg::POLY_LAST];

	always_comb begin
		if (flag_last.spec) begin
			sine_nx   = flag_last.sneg ? (18'd0 - sfcp_pkg::ONE_FIXED) : sfcp_pkg::ONE_FIXED;
			cosine_nx = 18'd0;
		end else begin
			sine_nx   = flag_last.sneg ? (18'd0 - smag) : smag;
			cosine_nx = flag_last.cneg ? (18'd0 - cmag) : cmag;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			sine_s10   <= $signed(sine_nx);
			cosine_s10 <= $signed(cosine_nx);
		end
	end

	assign sine   = sine_s10;
	assign cosine = cosine_s10;

	`SFCP_ASSERT_SAME(a_gap_ready, clk, arst_n, !(&valid_q), angle_ready)
	`SFCP_ASSERT_NEXT(a_take_first, clk, arst_n, angle_valid && angle_ready, valid_q[1])
	`SFCP_ASSERT_NEXT(a_hold_full, clk, arst_n, (&valid_q) && !result_ready, (&valid_q))

endmodule
